>>> sv/zcl_arp_pkg.sv
// ----------------------------------------------------------------------------
// zcl_arp_pkg
// Types, codes and helpers for the ZCL attribute record parser.
// ----------------------------------------------------------------------------
package zcl_arp_pkg;

  // Parser phase, one-hot
  typedef enum logic [5:0] {
    PH_HEADER = 6'b000001,
    PH_NUMBER = 6'b000010,
    PH_BOOL   = 6'b000100,
    PH_STRLEN = 6'b001000,
    PH_STRING = 6'b010000,
    PH_DROP   = 6'b100000
  } phase_t;

  // Result kinds
  localparam logic [1:0] KIND_RECORD  = 2'd0;
  localparam logic [1:0] KIND_STRBYTE = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;
  localparam logic [1:0] KIND_END     = 2'd3;

  // Value classes
  localparam logic [2:0] CLS_NONE     = 3'd0;
  localparam logic [2:0] CLS_BOOL     = 3'd1;
  localparam logic [2:0] CLS_UNSIGNED = 3'd2;
  localparam logic [2:0] CLS_SIGNED   = 3'd3;
  localparam logic [2:0] CLS_STRING   = 3'd4;

  // Error codes
  localparam logic [1:0] ERR_TRUNC    = 2'd0;
  localparam logic [1:0] ERR_BOOL     = 2'd1;
  localparam logic [1:0] ERR_UNSUP    = 2'd2;

  // ZCL type codes
  localparam logic [7:0] TYPE_NONE    = 8'h00;
  localparam logic [7:0] TYPE_BOOL    = 8'h10;
  localparam logic [7:0] TYPE_ENUM8   = 8'h30;
  localparam logic [7:0] TYPE_ENUM16  = 8'h31;
  localparam logic [7:0] TYPE_OCTSTR  = 8'h41;
  localparam logic [7:0] TYPE_CHARSTR = 8'h42;
  localparam logic [7:0] STR_LEN_NONE = 8'hFF;

  // Byte width of a numeric type, 0 when not numeric
  function automatic logic [3:0] num_width(input logic [7:0] t);
    logic [3:0] w;
    w = 4'd0;
    case (t) inside
      [8'h08:8'h0F], [8'h18:8'h2F]: w = {1'b0, t[2:0]} + 4'd1;
      TYPE_ENUM8:                   w = 4'd1;
      TYPE_ENUM16:                  w = 4'd2;
      default:                      w = 4'd0;
    endcase
    return w;
  endfunction

  // Signed type range
  function automatic logic is_signed_type(input logic [7:0] t);
    logic s;
    s = 1'b0;
    case (t) inside
      [8'h28:8'h2F]: s = 1'b1;
      default:       s = 1'b0;
    endcase
    return s;
  endfunction

endpackage

>>> sv/zcl_attribute_record_parser_core.sv
// ----------------------------------------------------------------------------
// zcl_attribute_record_parser_core
// Byte-serial parser for ZCL attribute record lists: id, type, value.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------
//   in      | into core | in_valid / in_stall  | data_byte, last_byte
//   out     | from core | out_valid / out_stall| record_kind, attr_id, type_code,
//           |           |                      | value_class, value_bits,
//           |           |                      | string_length, string_byte,
//           |           |                      | error_code, list_end
//
// One byte per cycle sustained while out_stall is low. A byte is held in the
// input register, the parse step runs between that register and the result
// register, and a result is loaded as its byte leaves the input register.
// Bytes that give no result (header bytes, leading value bytes, dropped
// bytes) retire without touching the result register.
// Synchronous reset returns the parser to the header phase with both
// registers empty. out_stall holds the result; a parked input byte then
// raises in_stall until the result register frees up.
// ----------------------------------------------------------------------------
module zcl_attribute_record_parser_core
  import zcl_arp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  record_kind,
  output logic [15:0] attr_id,
  output logic [7:0]  type_code,
  output logic [2:0]  value_class,
  output logic [63:0] value_bits,
  output logic [7:0]  string_length,
  output logic [7:0]  string_byte,
  output logic [1:0]  error_code,
  output logic        list_end
);

  // Input register
  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_last;

  // Parser state
  phase_t      phase,             phase_next;
  logic [3:0]  byte_count,        byte_count_next;
  logic [15:0] held_id,           held_id_next;
  logic [7:0]  held_type,         held_type_next;
  logic [63:0] value_accumulator, value_accumulator_next;
  logic [7:0]  string_remaining,  string_remaining_next;

  // Result of the current parse step
  logic        res;
  logic [1:0]  res_kind;
  logic [2:0]  res_class;
  logic [63:0] res_value;
  logic [7:0]  res_slen;
  logic [7:0]  res_sbyte;
  logic [1:0]  res_err;

  logic        out_free;
  logic        s1_adv;

  // Number helpers
  logic [3:0]  width;
  logic [63:0] acc_or;
  logic [3:0]  count_inc;
  logic [6:0]  sign_pos;
  logic [63:0] ext_value;
  logic [7:0]  rem_dec;

  // Handshake: a byte leaves the input register when its result (if any)
  // has somewhere to go.
  assign out_free = !out_valid || !out_stall;
  assign s1_adv   = s1_valid && (!res || out_free);
  assign in_stall = s1_valid && !s1_adv;

  always_comb begin
    width = num_width(held_type);
    if (width == 4'd0 || width > 4'd8) begin
      width = 4'd1;
    end
    acc_or    = value_accumulator
                | (64'(s1_byte) << {byte_count[2:0], 3'b000});
    count_inc = byte_count + 4'd1;
    sign_pos  = {width, 3'b000} - 7'd1;
    ext_value = acc_or;
    if (is_signed_type(held_type) && width < 4'd8 && acc_or[sign_pos[5:0]]) begin
      ext_value = acc_or | ({64{1'b1}} << {width, 3'b000});
    end
    rem_dec = (string_remaining != 8'd0) ? string_remaining - 8'd1 : string_remaining;
  end

  // Parse step
  always_comb begin
    phase_next             = phase;
    byte_count_next        = byte_count;
    held_id_next           = held_id;
    held_type_next         = held_type;
    value_accumulator_next = value_accumulator;
    string_remaining_next  = string_remaining;
    res       = 1'b0;
    res_kind  = KIND_RECORD;
    res_class = CLS_NONE;
    res_value = '0;
    res_slen  = '0;
    res_sbyte = '0;
    res_err   = ERR_TRUNC;

    case (phase)
      PH_HEADER: begin
        if (byte_count == 4'd0) begin
          held_id_next    = {8'h00, s1_byte};
          byte_count_next = 4'd1;
        end else if (byte_count == 4'd1) begin
          held_id_next    = held_id | {s1_byte, 8'h00};
          byte_count_next = 4'd2;
        end else begin
          held_type_next         = s1_byte;
          byte_count_next        = 4'd0;
          value_accumulator_next = '0;
          if (s1_byte == TYPE_NONE) begin
            res = 1'b1;
          end else if (s1_byte == TYPE_BOOL) begin
            phase_next = PH_BOOL;
          end else if (num_width(s1_byte) != 4'd0) begin
            phase_next = PH_NUMBER;
          end else if (s1_byte == TYPE_OCTSTR || s1_byte == TYPE_CHARSTR) begin
            phase_next = PH_STRLEN;
          end else begin
            res        = 1'b1;
            res_kind   = KIND_ERROR;
            res_err    = ERR_UNSUP;
            phase_next = PH_DROP;
          end
        end
      end
      PH_NUMBER: begin
        value_accumulator_next = acc_or;
        byte_count_next        = count_inc;
        if (count_inc >= width) begin
          value_accumulator_next = ext_value;
          res             = 1'b1;
          res_class       = is_signed_type(held_type) ? CLS_SIGNED : CLS_UNSIGNED;
          res_value       = ext_value;
          phase_next      = PH_HEADER;
          byte_count_next = 4'd0;
        end
      end
      PH_BOOL: begin
        res = 1'b1;
        if (s1_byte > 8'd1) begin
          res_kind   = KIND_ERROR;
          res_err    = ERR_BOOL;
          phase_next = PH_DROP;
        end else begin
          res_class  = CLS_BOOL;
          res_value  = 64'(s1_byte);
          phase_next = PH_HEADER;
        end
      end
      PH_STRLEN: begin
        res       = 1'b1;
        res_class = CLS_STRING;
        if (s1_byte == 8'd0 || s1_byte == STR_LEN_NONE) begin
          phase_next = PH_HEADER;
        end else begin
          res_slen              = s1_byte;
          string_remaining_next = s1_byte;
          phase_next            = PH_STRING;
        end
      end
      PH_STRING: begin
        res                   = 1'b1;
        res_kind              = KIND_STRBYTE;
        res_class             = CLS_STRING;
        res_sbyte             = s1_byte;
        string_remaining_next = rem_dec;
        if (rem_dec == 8'd0) begin
          phase_next = PH_HEADER;
        end
      end
      PH_DROP: begin
        // rest of buffer is discarded
      end
      default: begin
        phase_next = PH_HEADER;
      end
    endcase

    // Buffer end: list end marker, or truncation if a value is open
    if (s1_last) begin
      if (phase_next == PH_HEADER) begin
        if (!res) begin
          res      = 1'b1;
          res_kind = KIND_END;
        end
      end else if (phase_next != PH_DROP) begin
        res       = 1'b1;
        res_kind  = KIND_ERROR;
        res_err   = ERR_TRUNC;
        res_class = CLS_NONE;
        res_value = '0;
        res_slen  = '0;
        res_sbyte = '0;
      end
      phase_next            = PH_HEADER;
      byte_count_next       = 4'd0;
      string_remaining_next = 8'd0;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= data_byte;
      s1_last <= last_byte;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HEADER;
      byte_count        <= 4'd0;
      held_id           <= 16'd0;
      held_type         <= 8'd0;
      value_accumulator <= 64'd0;
      string_remaining  <= 8'd0;
    end else if (s1_adv) begin
      phase             <= phase_next;
      byte_count        <= byte_count_next;
      held_id           <= held_id_next;
      held_type         <= held_type_next;
      value_accumulator <= value_accumulator_next;
      string_remaining  <= string_remaining_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && res) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res) begin
      record_kind   <= res_kind;
      attr_id       <= (res_kind == KIND_END) ? 16'd0 : held_id_next;
      type_code     <= (res_kind == KIND_END) ? 8'd0 : held_type_next;
      value_class   <= res_class;
      value_bits    <= res_value;
      string_length <= res_slen;
      string_byte   <= res_sbyte;
      error_code    <= (res_kind == KIND_ERROR) ? res_err : ERR_TRUNC;
      list_end      <= s1_last;
    end
  end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ZCL attribute record parser core.
// A driver feeds attribute-list buffers byte by byte from a pending queue. It
// starts with hand-picked buffers, then random ones: mostly well-formed
// records, with noise, trailing bytes and cut-off buffers mixed in. Each
// accepted byte runs through a local parser model, and the monitor compares
// every result transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top
  import zcl_arp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // one predicted result transaction
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] id;
    logic [7:0]  ty;
    logic [2:0]  cls;
    logic [63:0] val;
    logic [7:0]  slen;
    logic [7:0]  sbyte;
    logic [1:0]  err;
    logic        lend;
  } zcl_result_t;

  // one input transaction; hold_for_drain makes the sender wait for an empty
  // result store before offering it
  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         hold_for_drain;
  } stream_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  record_kind;
  logic [15:0] attr_id;
  logic [7:0]  type_code;
  logic [2:0]  value_class;
  logic [63:0] value_bits;
  logic [7:0]  string_length;
  logic [7:0]  string_byte;
  logic [1:0]  error_code;
  logic        list_end;

  stream_byte_t byte_queue[$];       // bytes still to be offered
  zcl_result_t  awaited_results[$];  // predictions not yet matched
  logic [7:0]   frame[$];            // buffer under construction
  bit           want_long_string = 1'b1;

  int items_taken = 0;
  int errors = 0;
  logic calm;

  // Window with no idling on either side
  assign calm = (items_taken >= 600) && (items_taken < 760);

  // Parser model state
  phase_t      st_phase = PH_HEADER;
  logic [3:0]  st_count = 4'd0;
  logic [15:0] st_id    = 16'h0000;
  logic [7:0]  st_type  = 8'h00;
  logic [63:0] st_acc   = 64'd0;
  logic [7:0]  st_left  = 8'h00;

  zcl_attribute_record_parser_core u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .last_byte     (last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .record_kind   (record_kind),
    .attr_id       (attr_id),
    .type_code     (type_code),
    .value_class   (value_class),
    .value_bits    (value_bits),
    .string_length (string_length),
    .string_byte   (string_byte),
    .error_code    (error_code),
    .list_end      (list_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Value width in bytes of a numeric type code; 0 when not numeric
  function automatic int type_width(input logic [7:0] t);
    if ((t >= 8'h08 && t <= 8'h0F) || (t >= 8'h18 && t <= 8'h2F))
      return int'(t[2:0]) + 1;
    if (t == TYPE_ENUM8)
      return 1;
    if (t == TYPE_ENUM16)
      return 2;
    return 0;
  endfunction

  // Result fields from the held id/type; a bare list end carries neither
  function automatic zcl_result_t make_result(input logic [1:0] kind, input logic [2:0] cls,
                                              input logic [63:0] val, input logic [7:0] slen,
                                              input logic [7:0] sbyte, input logic [1:0] err);
    zcl_result_t r;
    r.kind  = kind;
    r.id    = (kind == KIND_END) ? 16'h0000 : st_id;
    r.ty    = (kind == KIND_END) ? 8'h00 : st_type;
    r.cls   = cls;
    r.val   = val;
    r.slen  = slen;
    r.sbyte = sbyte;
    r.err   = err;
    r.lend  = 1'b0;
    return r;
  endfunction

  // Advance the parser model by one byte; returns 1 when a result is due
  function automatic bit parse_byte(input logic [7:0] b, input logic lb,
                                    output zcl_result_t r);
    bit hit;
    bit sgn;
    int w;
    hit = 1'b0;
    r = '0;
    case (st_phase)
      PH_HEADER: begin
        if (st_count == 4'd0) begin
          st_id = {8'h00, b};
          st_count = 4'd1;
        end else if (st_count == 4'd1) begin
          st_id[15:8] = b;
          st_count = 4'd2;
        end else begin
          st_type = b;
          st_count = 4'd0;
          st_acc = 64'd0;
          if (b == TYPE_NONE) begin
            r = make_result(KIND_RECORD, CLS_NONE, 64'd0, 8'h00, 8'h00, ERR_TRUNC);
            hit = 1'b1;
          end else if (b == TYPE_BOOL) begin
            st_phase = PH_BOOL;
          end else if (type_width(b) != 0) begin
            st_phase = PH_NUMBER;
          end else if (b == TYPE_OCTSTR || b == TYPE_CHARSTR) begin
            st_phase = PH_STRLEN;
          end else begin
            r = make_result(KIND_ERROR, CLS_NONE, 64'd0, 8'h00, 8'h00, ERR_UNSUP);
            hit = 1'b1;
            st_phase = PH_DROP;
          end
        end
      end
      PH_NUMBER: begin
        w = type_width(st_type);
        if (w == 0)
          w = 1;
        st_acc = st_acc | ({56'd0, b} << (8 * st_count[2:0]));
        st_count = st_count + 4'd1;
        if (int'(st_count) >= w) begin
          sgn = (st_type >= 8'h28) && (st_type <= 8'h2F);
          // sign-extend from the top received bit
          if (sgn && w < 8 && st_acc[8 * w - 1])
            st_acc = st_acc | ({64{1'b1}} << (8 * w));
          r = make_result(KIND_RECORD, sgn ? CLS_SIGNED : CLS_UNSIGNED, st_acc,
                          8'h00, 8'h00, ERR_TRUNC);
          hit = 1'b1;
          st_phase = PH_HEADER;
          st_count = 4'd0;
        end
      end
      PH_BOOL: begin
        hit = 1'b1;
        if (b > 8'h01) begin
          r = make_result(KIND_ERROR, CLS_NONE, 64'd0, 8'h00, 8'h00, ERR_BOOL);
          st_phase = PH_DROP;
        end else begin
          r = make_result(KIND_RECORD, CLS_BOOL, {63'd0, b[0]}, 8'h00, 8'h00, ERR_TRUNC);
          st_phase = PH_HEADER;
        end
      end
      PH_STRLEN: begin
        hit = 1'b1;
        if (b == 8'h00 || b == STR_LEN_NONE) begin
          r = make_result(KIND_RECORD, CLS_STRING, 64'd0, 8'h00, 8'h00, ERR_TRUNC);
          st_phase = PH_HEADER;
        end else begin
          r = make_result(KIND_RECORD, CLS_STRING, 64'd0, b, 8'h00, ERR_TRUNC);
          st_left = b;
          st_phase = PH_STRING;
        end
      end
      PH_STRING: begin
        r = make_result(KIND_STRBYTE, CLS_STRING, 64'd0, 8'h00, b, ERR_TRUNC);
        hit = 1'b1;
        if (st_left != 8'h00)
          st_left = st_left - 8'h01;
        if (st_left == 8'h00)
          st_phase = PH_HEADER;
      end
      PH_DROP: ;
      default: st_phase = PH_HEADER;
    endcase

    // end of buffer: a bare list end, or a truncation error that replaces
    // whatever this byte gave; nothing while dropping
    if (lb) begin
      if (st_phase == PH_HEADER) begin
        if (!hit) begin
          r = make_result(KIND_END, CLS_NONE, 64'd0, 8'h00, 8'h00, ERR_TRUNC);
          hit = 1'b1;
        end
      end else if (st_phase != PH_DROP) begin
        r = make_result(KIND_ERROR, CLS_NONE, 64'd0, 8'h00, 8'h00, ERR_TRUNC);
        hit = 1'b1;
      end
      if (hit)
        r.lend = 1'b1;
      st_phase = PH_HEADER;
      st_count = 4'd0;
      st_left = 8'h00;
    end
    return hit;
  endfunction

  function automatic int field_diff(input string name, input logic [63:0] want,
                                    input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Move the buffer under construction into the byte queue, last flag on
  // its final byte
  task automatic queue_frame(input bit drain_first);
    stream_byte_t item;
    foreach (frame[i]) begin
      item.data = frame[i];
      item.last = (i == frame.size() - 1);
      item.hold_for_drain = drain_first && (i == 0);
      byte_queue.push_back(item);
    end
    frame.delete();
  endtask

  // Append one random record: id, type, value
  task automatic add_random_record();
    int pick;
    int w;
    int len;
    logic [7:0] ty;
    frame.push_back(8'($urandom_range(255)));
    frame.push_back(8'($urandom_range(255)));
    pick = $urandom_range(99);
    if (pick < 6) begin
      ty = TYPE_NONE;
    end else if (pick < 18) begin
      ty = TYPE_BOOL;
    end else if (pick < 38) begin
      ty = $urandom_range(1) ? TYPE_OCTSTR : TYPE_CHARSTR;
    end else if (pick < 42) begin
      // any code the parser does not know
      ty = 8'($urandom_range(255));
      while (ty == TYPE_NONE || ty == TYPE_BOOL || ty == TYPE_OCTSTR ||
             ty == TYPE_CHARSTR || type_width(ty) != 0)
        ty = 8'($urandom_range(255));
    end else begin
      pick = $urandom_range(33);
      if (pick < 8)
        ty = 8'(8'h08 + pick);
      else if (pick < 32)
        ty = 8'(8'h18 + pick - 8);
      else
        ty = (pick == 32) ? TYPE_ENUM8 : TYPE_ENUM16;
    end
    frame.push_back(ty);
    w = type_width(ty);
    if (ty == TYPE_BOOL) begin
      frame.push_back(($urandom_range(9) == 0) ? 8'($urandom_range(2, 255))
                                                : 8'($urandom_range(1)));
    end else if (ty == TYPE_OCTSTR || ty == TYPE_CHARSTR) begin
      pick = $urandom_range(99);
      if (want_long_string || pick == 0) begin
        len = $urandom_range(128, 254);
        want_long_string = 1'b0;
      end else if (pick < 10) begin
        len = 0;
      end else if (pick < 20) begin
        len = 255;
      end else begin
        len = $urandom_range(1, 8);
      end
      frame.push_back(8'(len));
      if (len != 0 && len != 255)
        repeat (len) frame.push_back(8'($urandom_range(255)));
    end else if (w != 0) begin
      repeat (w) frame.push_back(8'($urandom_range(255)));
      // push the top byte onto sign boundaries now and then
      case ($urandom_range(7))
        0: frame[frame.size() - 1] = 8'h80;
        1: frame[frame.size() - 1] = 8'h7F;
        2: frame[frame.size() - 1] = 8'hFF;
        3: frame[frame.size() - 1] = 8'h00;
        default: ;
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers the next byte when the channel is free. An accepted
  // transaction goes through the model at the edge that takes it.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : byte_driver
    zcl_result_t  predicted;
    stream_byte_t nxt;
    bit           offer;
    if (rst) begin
      in_valid <= 1'b0;
      st_phase = PH_HEADER;
      st_count = 4'd0;
      st_id = 16'h0000;
      st_type = 8'h00;
      st_acc = 64'd0;
      st_left = 8'h00;
    end else begin
      if (in_valid && !in_stall) begin
        if (parse_byte(data_byte, last_byte, predicted))
          awaited_results.push_back(predicted);
        items_taken <= items_taken + 1;
      end
      // a stalled byte stays put; otherwise pick what goes out next
      if (!in_valid || !in_stall) begin
        offer = (byte_queue.size() != 0);
        if (offer && byte_queue[0].hold_for_drain && awaited_results.size() != 0)
          offer = 1'b0;
        if (offer && !calm && $urandom_range(99) < 8)
          offer = 1'b0;
        if (offer) begin
          nxt = byte_queue.pop_front();
          in_valid  <= 1'b1;
          data_byte <= nxt.data;
          last_byte <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each result transaction and drives out_stall. Once, after
  // 400 bytes, it holds out_stall high for a while so that the core backs up.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    zcl_result_t want;
    int  hold_left;
    bit  hold_done;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind %0d id 0x%0h type 0x%0h",
                   $time, record_kind, attr_id, type_code);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          errors += field_diff("record_kind", want.kind, record_kind);
          errors += field_diff("attr_id", want.id, attr_id);
          errors += field_diff("type_code", want.ty, type_code);
          errors += field_diff("value_class", want.cls, value_class);
          errors += field_diff("value_bits", want.val, value_bits);
          errors += field_diff("string_length", want.slen, string_length);
          errors += field_diff("string_byte", want.sbyte, string_byte);
          errors += field_diff("error_code", want.err, error_code);
          errors += field_diff("list_end", want.lend, list_end);
        end
      end
      if (!hold_done && items_taken >= 400) begin
        hold_left = 80;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 8);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int  roll;
    int  n;
    int  k;
    bit  first;

    // none record, bool true, empty char string (0xFF length), one trailing
    // header byte giving a bare list end
    frame = '{8'hFF, 8'hFF, TYPE_NONE,
              8'h00, 8'h00, TYPE_BOOL, 8'h01,
              8'h02, 8'h00, TYPE_CHARSTR, STR_LEN_NONE,
              8'h12};
    queue_frame(1'b0);
    // int8 of -128 closing the buffer
    frame = '{8'h01, 8'h00, 8'h28, 8'h80};
    queue_frame(1'b0);
    // uint16 cut short by the end of buffer
    frame = '{8'h09, 8'h00, 8'h21, 8'hAB};
    queue_frame(1'b0);
    // bool byte out of range
    frame = '{8'h05, 8'h00, TYPE_BOOL, 8'h02};
    queue_frame(1'b0);
    // unknown type, then a dropped last byte
    frame = '{8'hAA, 8'h55, 8'hFF, 8'h07};
    queue_frame(1'b0);

    // random buffers; the first waits for the directed results to drain
    first = 1'b1;
    while (byte_queue.size() < 920) begin
      roll = $urandom_range(99);
      if (roll < 12) begin
        n = $urandom_range(1, 10);
        repeat (n) frame.push_back(8'($urandom_range(255)));
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) add_random_record();
        roll = $urandom_range(99);
        if (roll < 15) begin
          n = $urandom_range(1, 2);
          repeat (n) frame.push_back(8'($urandom_range(255)));
        end else if (roll < 40) begin
          k = $urandom_range(1, frame.size());
          while (frame.size() > k)
            void'(frame.pop_back());
        end
      end
      queue_frame(first || ($urandom_range(99) < 3));
      first = 1'b0;
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (byte_queue.size() != 0 || in_valid)
      @(posedge clk);
    while (awaited_results.size() != 0)
      @(posedge clk);
    // leave room for stray results
    repeat (10) @(posedge clk);

    if (errors == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

  // Watchdog, well beyond the slowest legal run
  initial begin : watchdog
    #2000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
